@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge outside reset
`define CHECK_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// condition that must hold at the clock edge after a trigger
`define CHECK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/rvc_pkg.sv @@
package rvc_pkg;

  localparam logic [1:0] OP_C1 = 2'b01;
  localparam logic [1:0] OP_C2 = 2'b10;

  localparam logic [2:0] F3_ADDI = 3'd0;
  localparam logic [2:0] F3_JAL  = 3'd1;
  localparam logic [2:0] F3_LI   = 3'd2;
  localparam logic [2:0] F3_JR   = 3'd4;
  localparam logic [2:0] F3_SWSP = 3'd6;

  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_RA   = 5'd1;
  localparam logic [4:0] REG_SP   = 5'd2;

  typedef struct packed {
    logic        en;
    logic [4:0]  addr;
    logic [31:0] data;
  } rvc_wr_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        wb_valid;
    logic [4:0]  wb_index;
    logic [31:0] wb_value;
    logic        store_valid;
    logic [31:0] store_addr;
    logic [31:0] store_data;
    logic        illegal;
  } rvc_res_t;

  // first read port: stack pointer for c.swsp, rs1 otherwise
  function automatic logic [4:0] rvc_addr_a(input logic [15:0] w);
    logic [4:0] a;
    a = w[11:7];
    if (w[1:0] == OP_C2 && w[15:13] == F3_SWSP) begin
      a = REG_SP;
    end
    return a;
  endfunction

endpackage

@@ hdl/rvc_regfile.sv @@
module rvc_regfile (
  input  logic           clk,
  input  logic           rst,
  input  logic           rd_en,
  input  logic [4:0]     ra_addr,
  input  logic [4:0]     rb_addr,
  input  rvc_pkg::rvc_wr_t wr,
  output logic [31:0]    ra_data,
  output logic [31:0]    rb_data
);
  import rvc_pkg::*;

  logic [31:0] mem [32];
  logic [31:0] vld;
  logic [31:0] q_a;
  logic [31:0] q_b;
  logic        vld_a;
  logic        vld_b;
  logic        fwd_a;
  logic        fwd_b;
  logic [31:0] fwd_data;

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read returns old data; a write at the same edge is forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_a      <= mem[ra_addr];
      q_b      <= mem[rb_addr];
      vld_a    <= vld[ra_addr];
      vld_b    <= vld[rb_addr];
      fwd_a    <= wr.en && (wr.addr == ra_addr);
      fwd_b    <= wr.en && (wr.addr == rb_addr);
      fwd_data <= wr.data;
    end
  end

  assign ra_data = fwd_a ? fwd_data : (vld_a ? q_a : '0);
  assign rb_data = fwd_b ? fwd_data : (vld_b ? q_b : '0);

endmodule

@@ hdl/rvc_exec.sv @@
module rvc_exec (
  input  logic [15:0]       instr,
  input  logic [31:0]       pc,
  input  logic [31:0]       ra_data,
  input  logic [31:0]       rb_data,
  output rvc_pkg::rvc_res_t res,
  output rvc_pkg::rvc_wr_t  wr
);
  import rvc_pkg::*;

  logic [1:0]  op;
  logic [2:0]  f3;
  logic [4:0]  r1;
  logic [4:0]  r2;
  logic [31:0] imm6;
  logic [31:0] joff;
  logic [31:0] soff;
  logic [31:0] pc_inc;
  logic        wr_any;
  logic [4:0]  widx;
  logic [31:0] wval;

  assign op     = instr[1:0];
  assign f3     = instr[15:13];
  assign r1     = instr[11:7];
  assign r2     = instr[6:2];
  assign imm6   = {{26{instr[12]}}, instr[12], instr[6:2]};
  assign joff   = {{20{instr[12]}}, instr[12], instr[8], instr[10:9], instr[6], instr[7],
                   instr[2], instr[11], instr[5:3], 1'b0};
  assign soff   = {24'd0, instr[8:7], instr[12:9], 2'b00};
  assign pc_inc = pc + 32'd2;

  always_comb begin
    res             = '0;
    res.next_pc     = pc_inc;
    wr_any          = 1'b0;
    widx            = REG_ZERO;
    wval            = '0;
    case (op)
      OP_C1: begin
        case (f3)
          F3_ADDI: begin
            wr_any = 1'b1;
            widx   = r1;
            wval   = ra_data + imm6;
          end
          F3_JAL: begin
            wr_any      = 1'b1;
            widx        = REG_RA;
            wval        = pc_inc;
            res.next_pc = pc + joff;
          end
          F3_LI: begin
            wr_any = 1'b1;
            widx   = r1;
            wval   = imm6;
          end
          default: res.illegal = 1'b1;
        endcase
      end
      OP_C2: begin
        case (f3)
          F3_JR: begin
            if (!instr[12] && r2 == REG_ZERO) begin
              res.next_pc = {ra_data[31:1], 1'b0};
            end else begin
              res.illegal = 1'b1;
            end
          end
          F3_SWSP: begin
            res.store_valid = 1'b1;
            res.store_addr  = ra_data + soff;
            res.store_data  = rb_data;
          end
          default: res.illegal = 1'b1;
        endcase
      end
      default: res.illegal = 1'b1;
    endcase
    if (wr_any && widx != REG_ZERO) begin
      res.wb_valid = 1'b1;
      res.wb_index = widx;
      res.wb_value = wval;
    end
  end

  assign wr.en   = res.wb_valid;
  assign wr.addr = res.wb_index;
  assign wr.data = res.wb_value;

endmodule

@@ hdl/rv32c_subset_executor_top.sv @@
// executes one 16-bit compressed instruction per transfer on the input channel
// (instr_valid, instr_stall, instr), fetched at the internal pc; one result per
// instruction leaves on the output channel (result_valid, result_stall, fields)
// one instruction per cycle is taken back to back while the receiver does not stall
// stage 1 registers the instruction while the register file memory is read
// (two read ports, read data registered); stage 2 executes, writes back and
// loads the output register; a write in flight is forwarded to the next read
// reset sets pc to RESET_PC, marks all registers as zero and empties both
// stages; it is done in the reset cycle, no clearing pass follows
// when the receiver stalls the output register holds, the executing stage
// holds behind it and instr_stall rises; nothing is lost or repeated
// next_pc is the fetch address of the following instruction
`include "assert_macros.svh"

module rv32c_subset_executor_top #(
  parameter logic [31:0] RESET_PC = 32'h0000_0200
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        instr_valid,
  output logic        instr_stall,
  input  logic [15:0] instr,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] next_pc,
  output logic        wb_valid,
  output logic [4:0]  wb_index,
  output logic [31:0] wb_value,
  output logic        store_valid,
  output logic [31:0] store_addr,
  output logic [31:0] store_data,
  output logic        illegal
);
  import rvc_pkg::*;

  logic        s1_valid;
  logic [15:0] s1_instr;
  logic [31:0] pc;
  logic        s1_adv;
  logic        in_xfer;
  logic [31:0] ra_data;
  logic [31:0] rb_data;
  rvc_res_t    res;
  rvc_wr_t     ex_wr;
  rvc_wr_t     wr;

  assign s1_adv      = s1_valid && (!result_valid || !result_stall);
  assign instr_stall = s1_valid && !s1_adv;
  assign in_xfer     = instr_valid && !instr_stall;

  assign wr.en   = ex_wr.en && s1_adv;
  assign wr.addr = ex_wr.addr;
  assign wr.data = ex_wr.data;

  rvc_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_xfer),
    .ra_addr (rvc_addr_a(instr)),
    .rb_addr (instr[6:2]),
    .wr      (wr),
    .ra_data (ra_data),
    .rb_data (rb_data)
  );

  rvc_exec u_exec (
    .instr   (s1_instr),
    .pc      (pc),
    .ra_data (ra_data),
    .rb_data (rb_data),
    .res     (res),
    .wr      (ex_wr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_instr <= instr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= RESET_PC;
    end else if (s1_adv) begin
      pc <= res.next_pc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      next_pc     <= res.next_pc;
      wb_valid    <= res.wb_valid;
      wb_index    <= res.wb_index;
      wb_value    <= res.wb_value;
      store_valid <= res.store_valid;
      store_addr  <= res.store_addr;
      store_data  <= res.store_data;
      illegal     <= res.illegal;
    end
  end

  `CHECK_ALWAYS(a_no_zero_wb, clk, rst, !(wr.en && wr.addr == REG_ZERO), "write to x0")
  `CHECK_ALWAYS(a_illegal_quiet, clk, rst, !(result_valid && illegal && (wb_valid || store_valid)), "illegal instruction has an effect")
  `CHECK_ALWAYS(a_store_no_wb, clk, rst, !(result_valid && store_valid && wb_valid), "store with writeback")
  `CHECK_NEXT(a_pc_follow, clk, rst, s1_adv, pc == $past(res.next_pc) && next_pc == pc, "pc out of step with result")
  `CHECK_NEXT(a_stage_hold, clk, rst, instr_stall, s1_valid && s1_instr == $past(s1_instr), "stalled instruction lost")

endmodule

@@ tb/tb_rv32c_subset_executor_top.sv @@
`timescale 1ns / 1ps

module tb_rv32c_subset_executor_top;
  import rvc_pkg::*;

  localparam logic [31:0] RESET_PC = 32'h0000_0200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASE_ITEMS = 150;

  logic        clk;
  logic        rst = 1'b1;
  logic        instr_valid = 1'b0;
  logic        instr_stall;
  logic [15:0] instr = 16'h0000;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [31:0] next_pc;
  logic        wb_valid;
  logic [4:0]  wb_index;
  logic [31:0] wb_value;
  logic        store_valid;
  logic [31:0] store_addr;
  logic [31:0] store_data;
  logic        illegal;

  rv32c_subset_executor_top #(
    .RESET_PC(RESET_PC)
  ) dut (
    .clk(clk),
    .rst(rst),
    .instr_valid(instr_valid),
    .instr_stall(instr_stall),
    .instr(instr),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .next_pc(next_pc),
    .wb_valid(wb_valid),
    .wb_index(wb_index),
    .wb_value(wb_value),
    .store_valid(store_valid),
    .store_addr(store_addr),
    .store_data(store_data),
    .illegal(illegal)
  );

  logic [15:0] fetch_q[$];
  rvc_res_t    pending_results[$];
  logic [31:0] arch_regs[32];
  logic [31:0] arch_pc;
  int          queued_count = 0;
  int          taken_count = 0;
  int          mismatch_count = 0;
  int          send_gap_pct = 0;
  int          stall_pct = 0;
  int          hold_reqs = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          idle_cycles = 0;
  logic        sent = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] enc_ci(input logic [2:0] f3, input logic [4:0] rd,
                                         input logic [5:0] imm);
    return {f3, imm[5], rd, imm[4:0], OP_C1};
  endfunction

  function automatic logic [15:0] enc_jal(input logic [11:0] off);
    return {F3_JAL, off[11], off[4], off[9:8], off[10], off[6], off[7], off[3:1], off[5], OP_C1};
  endfunction

  function automatic logic [15:0] enc_jr(input logic [4:0] rs1);
    return {F3_JR, 1'b0, rs1, REG_ZERO, OP_C2};
  endfunction

  function automatic logic [15:0] enc_swsp(input logic [7:0] off, input logic [4:0] rs2);
    return {F3_SWSP, off[5:2], off[7:6], rs2, OP_C2};
  endfunction

  // architectural execution of one instruction at arch_pc
  function automatic rvc_res_t execute_rvc(input logic [15:0] w);
    rvc_res_t    r;
    logic [31:0] imm;
    logic [31:0] off;
    logic [4:0]  rd;
    logic [4:0]  rs2;
    logic        do_wr;
    r = '0;
    rd = w[11:7];
    rs2 = w[6:2];
    imm = {{26{w[12]}}, w[12], w[6:2]};
    off = {{20{w[12]}}, w[12], w[8], w[10:9], w[6], w[7], w[2], w[11], w[5:3], 1'b0};
    r.next_pc = arch_pc + 32'd2;
    do_wr = 1'b0;
    if (w[1:0] == OP_C1 && w[15:13] == F3_ADDI) begin
      r.wb_index = rd;
      r.wb_value = arch_regs[rd] + imm;
      do_wr = 1'b1;
    end else if (w[1:0] == OP_C1 && w[15:13] == F3_JAL) begin
      r.wb_index = REG_RA;
      r.wb_value = arch_pc + 32'd2;
      do_wr = 1'b1;
      r.next_pc = arch_pc + off;
    end else if (w[1:0] == OP_C1 && w[15:13] == F3_LI) begin
      r.wb_index = rd;
      r.wb_value = imm;
      do_wr = 1'b1;
    end else if (w[1:0] == OP_C2 && w[15:13] == F3_JR && !w[12] && rs2 == REG_ZERO) begin
      r.next_pc = arch_regs[rd] & ~32'd1;
    end else if (w[1:0] == OP_C2 && w[15:13] == F3_SWSP) begin
      r.store_valid = 1'b1;
      r.store_addr = arch_regs[REG_SP] + {24'd0, w[8:7], w[12:9], 2'b00};
      r.store_data = arch_regs[rs2];
    end else begin
      r.illegal = 1'b1;
    end
    if (do_wr && r.wb_index != REG_ZERO) begin
      arch_regs[r.wb_index] = r.wb_value;
      r.wb_valid = 1'b1;
    end else begin
      r.wb_index = REG_ZERO;
      r.wb_value = '0;
    end
    arch_pc = r.next_pc;
    return r;
  endfunction

  // mostly legal programs with random operands, some near misses and raw noise
  function automatic logic [15:0] random_instr();
    int k;
    k = $urandom_range(99);
    if (k < 20) return enc_ci(F3_LI, 5'($urandom), 6'($urandom));
    if (k < 40) return enc_ci(F3_ADDI, 5'($urandom), 6'($urandom));
    if (k < 50) return enc_jal(12'($urandom));
    if (k < 58) return enc_jr(5'($urandom));
    if (k < 72) return enc_swsp(8'($urandom), 5'($urandom));
    if (k < 80) return {F3_JR, 11'($urandom), OP_C2};
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic queue_instr(input logic [15:0] w);
    fetch_q.push_back(w);
    queued_count++;
  endtask

  task automatic drain();
    while (taken_count != queued_count || pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%t: %s expected %h got %h", $realtime, name, want, got);
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      instr_valid <= 1'b0;
    end else if (!instr_valid || sent) begin
      if (fetch_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        instr_valid <= 1'b1;
        instr <= fetch_q.pop_front();
      end else begin
        instr_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with long hold-offs on request
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_served) begin
      result_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // input transfer prediction and result monitor
  always @(posedge clk) begin
    rvc_res_t want;
    rvc_res_t got;
    sent <= instr_valid && !instr_stall && !rst;
    if (!rst) begin
      if (instr_valid && !instr_stall) begin
        pending_results.push_back(execute_rvc(instr));
        taken_count++;
      end
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%t: result transfer with none expected", $realtime);
        end else begin
          want = pending_results.pop_front();
          got = {next_pc, wb_valid, wb_index, wb_value, store_valid, store_addr, store_data,
                 illegal};
          check_field("next_pc", want.next_pc, got.next_pc);
          check_field("wb_valid", 32'(want.wb_valid), 32'(got.wb_valid));
          check_field("wb_index", 32'(want.wb_index), 32'(got.wb_index));
          check_field("wb_value", want.wb_value, got.wb_value);
          check_field("store_valid", 32'(want.store_valid), 32'(got.store_valid));
          check_field("store_addr", want.store_addr, got.store_addr);
          check_field("store_data", want.store_data, got.store_data);
          check_field("illegal", 32'(want.illegal), 32'(got.illegal));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (instr_valid && !instr_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int gap_set[4];
    int stall_set[4];
    gap_set = '{0, 50, 0, 26};
    stall_set = '{0, 0, 50, 26};
    for (int i = 0; i < 32; i++) arch_regs[i] = '0;
    arch_pc = RESET_PC;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes, hints, wraps, near-miss encodings
    queue_instr(enc_ci(F3_LI, 5'd5, 6'h20));
    queue_instr(enc_ci(F3_LI, 5'd6, 6'h1f));
    queue_instr(enc_ci(F3_LI, REG_ZERO, 6'h15));
    queue_instr(enc_ci(F3_ADDI, REG_ZERO, 6'h00));
    queue_instr(enc_ci(F3_ADDI, 5'd5, 6'h3f));
    queue_instr(enc_ci(F3_ADDI, 5'd31, 6'h1f));
    queue_instr(enc_ci(F3_LI, 5'd7, 6'h3f));
    queue_instr(enc_ci(F3_ADDI, 5'd7, 6'h01));
    queue_instr(enc_ci(F3_LI, REG_SP, 6'h3c));
    queue_instr(enc_swsp(8'hfc, 5'd31));
    queue_instr(enc_swsp(8'h00, REG_ZERO));
    queue_instr(enc_swsp(8'h40, 5'd5));
    queue_instr(enc_jal(12'h7fe));
    queue_instr(enc_jal(12'h800));
    queue_instr(enc_jr(REG_ZERO));
    queue_instr(enc_jal(12'hffe));
    queue_instr(16'hffff);
    queue_instr(enc_jr(5'd5));
    queue_instr(enc_jr(REG_RA));
    queue_instr(16'h0000);
    queue_instr({F3_JR, 1'b1, 5'd3, REG_ZERO, OP_C2});
    queue_instr({F3_JR, 1'b0, 5'd3, 5'd4, OP_C2});
    queue_instr({3'd3, 11'h7ff, OP_C1});
    queue_instr({3'd7, 11'h555, OP_C2});
    drain();

    for (int p = 0; p < 4; p++) begin
      send_gap_pct = gap_set[p];
      stall_pct = stall_set[p];
      for (int i = 0; i < PHASE_ITEMS; i++) queue_instr(random_instr());
      drain();
    end

    // long receiver hold-off with the sender pushing back to back
    send_gap_pct = 0;
    stall_pct = 0;
    hold_reqs++;
    for (int i = 0; i < 60; i++) queue_instr(random_instr());
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/rvc_pkg.sv
hdl/rvc_regfile.sv
hdl/rvc_exec.sv
hdl/rv32c_subset_executor_top.sv
tb/tb_rv32c_subset_executor_top.sv
